[rtl/rate_limited_diff_drive_mixer_defines.svh]
// Assertion macros for the rate-limited differential drive mixer.
// Used by the top level only; no other dependencies.
`ifndef RATE_LIMITED_DIFF_DRIVE_MIXER_DEFINES_SVH
`define RATE_LIMITED_DIFF_DRIVE_MIXER_DEFINES_SVH
`ifndef ASSERT_OFF
`define RLDDM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rate limited mixer check failed");
`define RLDDM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rate limited mixer check failed");
`else
`define RLDDM_ASSERT(label, clk, rst, prop)
`define RLDDM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[rtl/rlddm_pkg.sv]
// Shared types, register indexes and reset values for the mixer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package rlddm_pkg;

  typedef struct packed {
    logic signed [15:0] linear_cmd;
    logic signed [15:0] angular_cmd;
    logic [31:0]        arrival_time;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
  } wheel_t;

  typedef enum logic [1:0] {
    CFG_LINEAR_STEP  = 2'd0,
    CFG_ANGULAR_STEP = 2'd1,
    CFG_TRACK_GAIN   = 2'd2
  } cfg_index_t;

  localparam logic [15:0] LINEAR_STEP_RESET  = 16'd66;
  localparam logic [15:0] ANGULAR_STEP_RESET = 16'd66;
  localparam logic [19:0] TRACK_GAIN_RESET   = 20'd19661;
  localparam logic [15:0] LIMIT_MAX          = 16'hFFFF;

  typedef struct packed {
    logic capture;
    logic mul_en;
    logic slew_en;
    logic mix_en;
    logic out_load;
  } dp_ctrl_t;

endpackage

[rtl/rlddm_dp.sv]
// Datapath of the mixer: configuration registers, history, slew limiting and mixing.
// Depends on rlddm_pkg; driven by rlddm_ctrl through rlddm_pkg::dp_ctrl_t.
`timescale 1ns / 1ps
module rlddm_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  rlddm_pkg::dp_ctrl_t    ctrl,
  input  rlddm_pkg::cmd_t        cmd,
  input  logic                   cfg_write,
  input  rlddm_pkg::cfg_index_t  cfg_index,
  input  logic [31:0]            cfg_data,
  output rlddm_pkg::wheel_t      wheel
);

  logic [15:0]        linear_step;
  logic [15:0]        angular_step;
  logic [19:0]        track_gain;
  logic signed [15:0] prev_linear;
  logic signed [15:0] prev_angular;
  logic [31:0]        last_time;
  logic               have_previous;

  logic signed [15:0] linear_in;
  logic signed [15:0] angular_in;
  logic [31:0]        elapsed;
  logic               limited;
  logic [15:0]        linear_lim;
  logic [15:0]        angular_lim;
  logic signed [36:0] mix_prod;

  logic [47:0]        linear_prod;
  logic [47:0]        angular_prod;
  logic signed [15:0] linear_slewed;
  logic signed [15:0] angular_slewed;
  logic signed [37:0] rounded;
  logic signed [21:0] term_wide;
  logic signed [15:0] term;
  logic signed [17:0] left_sum;
  logic signed [17:0] right_sum;

  function automatic logic [15:0] sat_limit(input logic [47:0] prod);
    if (|prod[47:32]) begin
      return rlddm_pkg::LIMIT_MAX;
    end
    return prod[31:16];
  endfunction

  function automatic logic signed [15:0] slew16(input logic signed [15:0] prev,
                                                input logic signed [15:0] target,
                                                input logic [15:0] lim);
    logic signed [17:0] d;
    logic signed [17:0] l;
    logic signed [17:0] r;
    d = 18'(target) - 18'(prev);
    l = signed'({2'b00, lim});
    if (d > l) begin
      r = 18'(prev) + l;
    end else if (d < -l) begin
      r = 18'(prev) - l;
    end else begin
      r = 18'(target);
    end
    return r[15:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    if (v > 22'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -22'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  assign linear_prod    = 48'(linear_step) * 48'(elapsed);
  assign angular_prod   = 48'(angular_step) * 48'(elapsed);
  assign linear_slewed  = limited ? slew16(prev_linear, linear_in, linear_lim) : linear_in;
  assign angular_slewed = limited ? slew16(prev_angular, angular_in, angular_lim) : angular_in;

  // Round to nearest with ties upwards, then saturate the mixing term.
  assign rounded   = 38'(mix_prod) + 38'sd32768;
  assign term_wide = rounded[37:16];
  assign term      = sat16(term_wide);
  assign left_sum  = 18'(prev_linear) - 18'(term);
  assign right_sum = 18'(prev_linear) + 18'(term);

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_step   <= rlddm_pkg::LINEAR_STEP_RESET;
      angular_step  <= rlddm_pkg::ANGULAR_STEP_RESET;
      track_gain    <= rlddm_pkg::TRACK_GAIN_RESET;
      prev_linear   <= '0;
      prev_angular  <= '0;
      last_time     <= '0;
      have_previous <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          rlddm_pkg::CFG_LINEAR_STEP:  linear_step  <= cfg_data[15:0];
          rlddm_pkg::CFG_ANGULAR_STEP: angular_step <= cfg_data[15:0];
          rlddm_pkg::CFG_TRACK_GAIN:   track_gain   <= cfg_data[19:0];
          default: ;
        endcase
      end
      if (ctrl.capture) begin
        last_time     <= cmd.arrival_time;
        have_previous <= 1'b1;
      end
      if (ctrl.slew_en) begin
        prev_linear  <= linear_slewed;
        prev_angular <= angular_slewed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      linear_in  <= cmd.linear_cmd;
      angular_in <= cmd.angular_cmd;
      elapsed    <= cmd.arrival_time - last_time;
      limited    <= have_previous;
    end
    if (ctrl.mul_en) begin
      linear_lim  <= sat_limit(linear_prod);
      angular_lim <= sat_limit(angular_prod);
    end
    if (ctrl.mix_en) begin
      mix_prod <= 37'(signed'({1'b0, track_gain})) * 37'(prev_angular);
    end
    if (ctrl.out_load) begin
      wheel.left_speed  <= sat16(22'(left_sum));
      wheel.right_speed <= sat16(22'(right_sum));
    end
  end

endmodule

[rtl/rlddm_ctrl.sv]
// Sequencing controller of the mixer: request handshakes and datapath step enables.
// Depends on rlddm_pkg for the datapath control struct.
`timescale 1ns / 1ps
module rlddm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  output logic                wheel_valid,
  input  logic                wheel_stall,
  output rlddm_pkg::dp_ctrl_t ctrl
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SLEW = 5'b00100,
    S_MIX  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;

  assign out_free  = !(wheel_valid && wheel_stall);
  assign cmd_stall = !((state == S_IDLE) || ((state == S_FIN) && out_free));
  assign accept    = cmd_valid && !cmd_stall;

  always_comb begin
    ctrl.capture  = accept;
    ctrl.mul_en   = (state == S_MUL);
    ctrl.slew_en  = (state == S_SLEW);
    ctrl.mix_en   = (state == S_MIX);
    ctrl.out_load = (state == S_FIN) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_MUL;
      S_MUL:  state_next = S_SLEW;
      S_SLEW: state_next = S_MIX;
      S_MIX:  state_next = S_FIN;
      S_FIN: begin
        if (accept) begin
          state_next = S_MUL;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      wheel_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.out_load) begin
        wheel_valid <= 1'b1;
      end else if (!wheel_stall) begin
        wheel_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/rate_limited_diff_drive_mixer.sv]
// Top level of the rate-limited differential drive mixer.
// Depends on rlddm_pkg, rlddm_ctrl, rlddm_dp and the assertion macro header.
//
//  channel | direction | handshake           | payload
//  cmd     | in        | cmd_valid/cmd_stall | rlddm_pkg::cmd_t
//  wheel   | out       | wheel_valid/stall   | rlddm_pkg::wheel_t
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A command passes through the steps limit multiply, slew, mix multiply, round and saturate.
// The next command is taken in the cycle the result is loaded, so a request is taken
// only once the previous one reaches its final step; the controller sequences the one shared datapath.
// Reset is synchronous and restores register defaults and clears the history.
// A stalled result holds the output register and the final step waits for it.
`timescale 1ns / 1ps
`include "rate_limited_diff_drive_mixer_defines.svh"
module rate_limited_diff_drive_mixer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  rlddm_pkg::cmd_t       cmd,
  output logic                  wheel_valid,
  input  logic                  wheel_stall,
  output rlddm_pkg::wheel_t     wheel,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  rlddm_pkg::cfg_index_t cfg_index,
  input  logic [31:0]           cfg_data
);

  rlddm_pkg::dp_ctrl_t ctrl;

  assign cfg_ready = 1'b1;

  rlddm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .wheel_valid (wheel_valid),
    .wheel_stall (wheel_stall),
    .ctrl        (ctrl)
  );

  rlddm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cmd       (cmd),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wheel     (wheel)
  );

  `RLDDM_ASSERT(busy_after_accept, clk, rst, (cmd_valid && !cmd_stall) |=> cmd_stall)
  `RLDDM_ASSERT(no_result_overwrite, clk, rst, ctrl.out_load |-> !(wheel_valid && wheel_stall))
  `RLDDM_ASSERT(one_step_at_a_time, clk, rst, $onehot0({ctrl.mul_en, ctrl.slew_en, ctrl.mix_en}))
  `RLDDM_ASSERT_ALWAYS(reset_state, clk, rst |=> (!wheel_valid && !cmd_stall))

endmodule
